FILE: sv/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared sizes, codes and control/status bundles of the min tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int DEPTH = 64;
  localparam int WIDTH = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic refill;
    logic load_out;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_refill;
    logic out_hold;
  } dp_stat_t;

endpackage

FILE: sv/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// Sequencer: accept a beat, execute, refill cached tops after a pop of a nonempty stack, publish.
// ----------------------------------------------------------------------------
module mts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mts_pkg::dp_stat_t stat,
  output mts_pkg::ctl_cmd_t ctl
);
  import mts_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REFILL,
    S_DONE
  } state_t;

  state_t state_r;
  logic   stall_r;

  assign in_stall = stall_r;

  always_comb begin
    ctl          = '0;
    ctl.capture  = (state_r == S_IDLE) && in_valid && !stall_r;
    ctl.exec     = (state_r == S_EXEC);
    ctl.refill   = (state_r == S_REFILL);
    ctl.load_out = (state_r == S_DONE) && !stat.out_hold;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stall_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid && !stall_r) begin
            state_r <= S_EXEC;
            stall_r <= 1'b1;
          end
        end
        S_EXEC: begin
          state_r <= stat.need_refill ? S_REFILL : S_DONE;
        end
        S_REFILL: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          // wait for the output register to free up
          if (!stat.out_hold) begin
            state_r <= S_IDLE;
            stall_r <= 1'b0;
          end
        end
        default: begin
          state_r <= S_IDLE;
          stall_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: sv/mts_dp.sv
// ----------------------------------------------------------------------------
// mts_dp
// Value and minimum stores, counts, cached top words and result register.
// ----------------------------------------------------------------------------
module mts_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mts_pkg::ctl_cmd_t                    ctl,
  output mts_pkg::dp_stat_t                    stat,
  input  logic [1:0]                           in_cmd,
  input  logic signed [mts_pkg::WIDTH-1:0]     in_push_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mts_pkg::WIDTH-1:0]     out_top_value,
  output logic signed [mts_pkg::WIDTH-1:0]     out_min_value,
  output logic [mts_pkg::CW-1:0]               out_depth_count,
  output logic                                 out_is_empty,
  output logic [1:0]                           out_status
);
  import mts_pkg::*;

  logic signed [WIDTH-1:0] value_mem [DEPTH];
  logic signed [WIDTH-1:0] min_mem   [DEPTH];

  logic [1:0]              cmd_r;
  logic signed [WIDTH-1:0] val_r;
  logic [CW-1:0]           vcnt_r, mcnt_r;
  logic signed [WIDTH-1:0] top_r, mtop_r;
  logic signed [WIDTH-1:0] rd_val_r, rd_min_r;
  status_e                 status_r;

  logic signed [WIDTH-1:0] res_top_r, res_min_r;
  logic [CW-1:0]           res_depth_r;
  logic                    res_empty_r;
  logic [1:0]              res_status_r;
  logic                    out_valid_r;

  logic                    is_push, is_pop, is_full, is_none;
  logic                    min_push, min_pop;
  logic [CW-1:0]           vcnt_dec, mcnt_new;
  logic [AW-1:0]           rd_vaddr, rd_maddr;

  always_comb begin
    is_push  = (cmd_r == CMD_PUSH);
    is_pop   = (cmd_r == CMD_POP);
    is_full  = (vcnt_r == CW'(DEPTH));
    is_none  = (vcnt_r == '0);
    // equal values go on the min stack too, so a pop of one copy keeps the min
    min_push = (mcnt_r == '0) || (val_r <= mtop_r);
    min_pop  = (mcnt_r != '0) && (mtop_r == top_r);
    vcnt_dec = vcnt_r - CW'(1);
    mcnt_new = min_pop ? (mcnt_r - CW'(1)) : mcnt_r;
    // entry that becomes the new top after a pop; only used when the new count is nonzero
    rd_vaddr = vcnt_dec[AW-1:0] - AW'(1);
    rd_maddr = mcnt_new[AW-1:0] - AW'(1);
  end

  assign stat.need_refill = is_pop && !is_none;
  assign stat.out_hold    = out_valid_r && out_stall;

  // stores: one write port each, registered read
  always_ff @(posedge clk) begin
    if (ctl.exec && is_push && !is_full) begin
      value_mem[vcnt_r[AW-1:0]] <= val_r;
      if (min_push) begin
        min_mem[mcnt_r[AW-1:0]] <= val_r;
      end
    end
    rd_val_r <= value_mem[rd_vaddr];
    rd_min_r <= min_mem[rd_maddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= in_cmd;
      val_r <= in_push_value;
    end
    if (ctl.exec) begin
      if (is_push && !is_full) begin
        top_r <= val_r;
        if (min_push) begin
          mtop_r <= val_r;
        end
      end
    end
    if (ctl.refill) begin
      if (vcnt_r != '0) begin
        top_r <= rd_val_r;
      end
      if (mcnt_r != '0) begin
        mtop_r <= rd_min_r;
      end
    end
    if (ctl.load_out) begin
      res_top_r    <= (vcnt_r != '0) ? top_r : '0;
      res_min_r    <= (mcnt_r != '0) ? mtop_r : '0;
      res_depth_r  <= vcnt_r;
      res_empty_r  <= (vcnt_r == '0);
      res_status_r <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r      <= '0;
      mcnt_r      <= '0;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.exec) begin
        status_r <= ST_OK;
        if (is_push) begin
          if (is_full) begin
            status_r <= ST_FULL;
          end else begin
            vcnt_r <= vcnt_r + CW'(1);
            if (min_push) begin
              mcnt_r <= mcnt_r + CW'(1);
            end
          end
        end else if (is_pop) begin
          if (is_none) begin
            status_r <= ST_EMPTY;
          end else begin
            vcnt_r <= vcnt_dec;
            mcnt_r <= mcnt_new;
          end
        end
      end
      if (ctl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_top_value   = res_top_r;
  assign out_min_value   = res_min_r;
  assign out_depth_count = res_depth_r;
  assign out_is_empty    = res_empty_r;
  assign out_status      = res_status_r;

endmodule

FILE: sv/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// min_tracking_stack
// LIFO stack of signed words that also reports its running minimum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: in_cmd (push, pop, peek; code 3 acts as peek) and
//   in_push_value. A beat moves when in_valid is high and in_stall is low.
//   Result channel out_*: one beat per input beat with top, minimum, depth,
//   empty flag and status (ok, pop on empty, push on full). The receiver
//   holds out_stall high to keep a beat; the payload then stays put.
//   The result is registered once the beat has passed the execute state
//   and, for a pop of a nonempty stack, the refill state, which rereads both
//   stores through their registered read ports to refresh the cached tops.
//   Beats are not overlapped inside the block; the sequencer handles
//   one beat at a time. A new beat may be taken while the last result still
//   sits in the output register; a stalled result holds the next one back.
//   Reset (rst_n low, synchronous) empties both stacks and drops out_valid.
//   Store contents are not cleared; entries are used only once written.
// ----------------------------------------------------------------------------
module min_tracking_stack (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_cmd,
  input  logic signed [mts_pkg::WIDTH-1:0] in_push_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [mts_pkg::WIDTH-1:0] out_top_value,
  output logic signed [mts_pkg::WIDTH-1:0] out_min_value,
  output logic [mts_pkg::CW-1:0]           out_depth_count,
  output logic                             out_is_empty,
  output logic [1:0]                       out_status
);
  import mts_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t stat;

  mts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  mts_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .stat            (stat),
    .in_cmd          (in_cmd),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_top_value   (out_top_value),
    .out_min_value   (out_min_value),
    .out_depth_count (out_depth_count),
    .out_is_empty    (out_is_empty),
    .out_status      (out_status)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("beat accepted while another is in flight");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |->
      out_depth_count == '0 && out_top_value == '0 && out_min_value == '0)
    else $error("empty result carries nonzero fields");

  a_min_le_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_empty |-> out_min_value <= out_top_value)
    else $error("minimum above top value");

  a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_depth_count == CW'(DEPTH))
    else $error("push refused below full depth");

endmodule

FILE: test/tb_min_tracking_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_tracking_stack
// Self-checking bench for the min tracking stack: drives push, pop and peek
// beats with random idling on both channels, mirrors the value and minimum
// stacks in a scoreboard and compares every result beat field by field.
// ----------------------------------------------------------------------------
module tb_min_tracking_stack;
  import mts_pkg::*;

  typedef struct packed {
    logic signed [WIDTH-1:0] top;
    logic signed [WIDTH-1:0] minimum;
    logic [CW-1:0]           depth;
    logic                    empty;
    logic [1:0]              status;
  } stack_view_t;

  class min_stack_checker;
    logic signed [WIDTH-1:0] vals [DEPTH];
    logic signed [WIDTH-1:0] mins [DEPTH];
    int unsigned             n_vals;
    int unsigned             n_mins;
    stack_view_t             expected_views [$];
    int                      errors;

    function new();
      n_vals = 0;
      n_mins = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_views.size();
    endfunction

    // Apply one accepted operation and queue the view of the stack after it.
    function void note_op(logic [1:0] cmd, logic signed [WIDTH-1:0] x);
      stack_view_t v;
      v.status = ST_OK;
      case (cmd)
        CMD_PUSH: begin
          if (n_vals == DEPTH) begin
            v.status = ST_FULL;
          end else begin
            vals[n_vals] = x;
            n_vals++;
            // equal values go on the min stack too, so one pop keeps the min
            if (n_mins == 0 || x <= mins[n_mins-1]) begin
              mins[n_mins] = x;
              n_mins++;
            end
          end
        end
        CMD_POP: begin
          if (n_vals == 0) begin
            v.status = ST_EMPTY;
          end else begin
            if (n_mins > 0 && mins[n_mins-1] == vals[n_vals-1]) n_mins--;
            n_vals--;
          end
        end
        default: ;  // peek and the spare code leave the stack alone
      endcase
      v.top     = (n_vals > 0) ? vals[n_vals-1] : '0;
      v.minimum = (n_mins > 0) ? mins[n_mins-1] : '0;
      v.depth   = n_vals[CW-1:0];
      v.empty   = (n_vals == 0);
      expected_views.push_back(v);
    endfunction

    function void check_beat(logic signed [WIDTH-1:0] top,
                             logic signed [WIDTH-1:0] minimum,
                             logic [CW-1:0] depth, logic empty, logic [1:0] status);
      stack_view_t v;
      if (expected_views.size() == 0) begin
        $error("result beat with no operation pending");
        errors++;
        return;
      end
      v = expected_views.pop_front();
      if (top !== v.top) begin
        $error("top_value: expected %0d, got %0d", v.top, top);
        errors++;
      end
      if (minimum !== v.minimum) begin
        $error("min_value: expected %0d, got %0d", v.minimum, minimum);
        errors++;
      end
      if (depth !== v.depth) begin
        $error("depth_count: expected %0d, got %0d", v.depth, depth);
        errors++;
      end
      if (empty !== v.empty) begin
        $error("is_empty: expected %0d, got %0d", v.empty, empty);
        errors++;
      end
      if (status !== v.status) begin
        $error("status: expected %0d, got %0d", v.status, status);
        errors++;
      end
    endfunction
  endclass

  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT = 100000;
  localparam int         TAIL_CYCLES = 20;
  localparam int         HOLD_CYCLES = 300;

  localparam logic signed [WIDTH-1:0] MAX_VAL = {1'b0, {(WIDTH-1){1'b1}}};
  localparam logic signed [WIDTH-1:0] MIN_VAL = {1'b1, {(WIDTH-1){1'b0}}};

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              in_cmd;
  logic signed [WIDTH-1:0] in_push_value;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [WIDTH-1:0] out_top_value;
  logic signed [WIDTH-1:0] out_min_value;
  logic [CW-1:0]           out_depth_count;
  logic                    out_is_empty;
  logic [1:0]              out_status;

  min_stack_checker chk = new();

  bit gapless;      // no idling on either side while set
  int rx_hold;      // long receiver hold-off, loaded once by the stimulus
  int rx_wait;
  int cycle_count;

  min_tracking_stack u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_top_value   (out_top_value),
    .out_min_value   (out_min_value),
    .out_depth_count (out_depth_count),
    .out_is_empty    (out_is_empty),
    .out_status      (out_status)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int draw_gap();
    return gapless ? 0 : $urandom_range(0, 7);
  endfunction

  // Small values often, so equal minimums come up often, plus extremes and random words.
  function automatic logic signed [WIDTH-1:0] draw_value();
    int s;
    s = int'($urandom_range(0, 8)) - 4;
    case ($urandom_range(0, 9))
      0:          return MAX_VAL;
      1:          return MIN_VAL;
      2, 3, 4, 5: return WIDTH'(s);
      default:    return WIDTH'($urandom());
    endcase
  endfunction

  // input beats are noted at the edge that moves them
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) chk.note_op(in_cmd, in_push_value);
  end

  // receiver: per-beat stall draw, plus the long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        chk.check_beat(out_top_value, out_min_value, out_depth_count, out_is_empty,
                       out_status);
        rx_wait = draw_gap();
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= (rx_hold > 0) || (rx_wait > 0);
      if (rx_hold > 0) rx_hold--;
    end
  end

  task automatic send_op(input logic [1:0] cmd, input logic signed [WIDTH-1:0] value);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_push_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // wait for an edge first so the beat accepted at this edge is already counted
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk.pending() != 0) @(posedge clk);
  endtask

  task automatic random_ops(input int count, input int push_pct);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < push_pct)
        send_op(CMD_PUSH, draw_value());
      else if (r < push_pct + (100 - push_pct) * 3 / 4)
        send_op(CMD_POP, draw_value());
      else if ($urandom_range(0, 1))
        send_op(CMD_PEEK, draw_value());
      else
        send_op(CMD_SPARE, draw_value());
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cmd        <= CMD_PEEK;
    in_push_value <= '0;
    gapless       = 1'b0;
    rx_hold       = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-stack corners, extremes, equal minimum, spare code
    send_op(CMD_PEEK, 0);
    send_op(CMD_POP, 0);
    send_op(CMD_SPARE, 0);
    send_op(CMD_PUSH, 0);
    send_op(CMD_PUSH, MAX_VAL);
    send_op(CMD_PUSH, MIN_VAL);
    send_op(CMD_PUSH, MIN_VAL);
    send_op(CMD_PEEK, 0);
    send_op(CMD_POP, 0);
    send_op(CMD_POP, 0);
    send_op(CMD_PUSH, -1);
    send_op(CMD_PUSH, WIDTH'(32'h5555_5555));
    send_op(CMD_PUSH, WIDTH'(32'hAAAA_AAAA));
    send_op(CMD_SPARE, -1);
    send_op(CMD_PUSH, 5);
    send_op(CMD_PUSH, 5);
    send_op(CMD_PUSH, 7);
    for (int i = 0; i < 8; i++) send_op(CMD_POP, 0);
    wait_all_results();

    // fill past full, then drain past empty, no idling on the first half
    gapless = 1'b1;
    for (int i = 0; i < 70; i++) send_op(CMD_PUSH, draw_value());
    gapless = 1'b0;
    for (int i = 0; i < 72; i++) send_op(CMD_POP, 0);

    // receiver holds off while the sender keeps offering beats
    @(negedge clk);
    rx_hold = HOLD_CYCLES;
    @(posedge clk);
    random_ops(30, 60);
    wait_all_results();

    for (int blk = 0; blk < 10; blk++) begin
      gapless = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0:       random_ops(25, 30);
        1:       random_ops(25, 50);
        default: random_ops(25, 75);
      endcase
    end
    gapless = 1'b0;

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (chk.errors == 0 && chk.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
sv/mts_pkg.sv
sv/mts_ctrl.sv
sv/mts_dp.sv
sv/min_tracking_stack.sv
test/tb_min_tracking_stack.sv
